[sv/nevs_pkg.sv]
// Package for the nearest earlier value search: sizes, query and result types.
// Depends on nothing; used by the interfaces, the cells, the output buffer and the top.
`default_nettype none

package nevs_pkg;

  localparam int DEPTH     = 1024;
  localparam int VAL_W     = 32;
  localparam int POS_OUT_W = 11;
  localparam int COUNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int POS_W     = COUNT_W;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] x;
    logic [COUNT_W-1:0]      limit;
    logic                    full;
    logic [VAL_W-1:0]        best_dist;
    logic signed [VAL_W-1:0] best_val;
    logic [POS_W-1:0]        best_pos;
  } query_t;

  typedef struct packed {
    logic [VAL_W-1:0]     distance;
    logic [POS_OUT_W-1:0] partner_position;
    logic                 store_full;
  } result_t;

endpackage

`default_nettype wire

[sv/nevs_ifs.sv]
// Valid/ready channel interfaces for sample input and search results.
// Depends on nevs_pkg for field widths.
`default_nettype none

interface nevs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [nevs_pkg::VAL_W-1:0] sample_value;
  logic                              start_sequence;

  modport source (output valid, output sample_value, output start_sequence, input ready);
  modport sink (input valid, input sample_value, input start_sequence, output ready);
endinterface

interface nevs_out_if;
  logic                          valid;
  logic                          ready;
  logic [nevs_pkg::VAL_W-1:0]     distance;
  logic [nevs_pkg::POS_OUT_W-1:0] partner_position;
  logic                          store_full;

  modport source (output valid, output distance, output partner_position,
                  output store_full, input ready);
  modport sink (input valid, input distance, input partner_position,
                input store_full, output ready);
endinterface

`default_nettype wire

[sv/nearest_earlier_value_search.sv]
// Nearest earlier value search: a chain of DEPTH compare cells, one stored value each.
// Throughput: one item per cycle while no skid entry stalls the chain; the query passes
// one cell per cycle down the chain to the output register (cell 0 loads at the transfer).
// A first item of a sequence gives no result. Reset clears the item count and all stage
// valids; stored values are undefined until written and need no clearing pass.
// Depends on nevs_pkg, nevs_ifs, nevs_cell and nevs_out_buf.
`default_nettype none

module nearest_earlier_value_search (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nevs_in_if.sink    in_chan,
  nevs_out_if.source out_chan
);

  logic [nevs_pkg::COUNT_W-1:0] count_r;
  logic [nevs_pkg::COUNT_W-1:0] count_nxt;
  logic                         advance;
  logic                         accept;
  logic                         first;
  logic                         full;
  logic                         store_wr;
  logic [nevs_pkg::IDX_W-1:0]   wr_idx;
  nevs_pkg::query_t             chain [0:nevs_pkg::DEPTH];
  nevs_pkg::query_t             tail;
  nevs_pkg::result_t            res;

  assign in_chan.ready = advance;
  assign accept        = in_chan.valid && advance;
  assign first         = in_chan.start_sequence || (count_r == '0);
  assign full          = (count_r == nevs_pkg::COUNT_W'(nevs_pkg::DEPTH));
  assign store_wr      = accept && (first || !full);
  assign wr_idx        = first ? '0 : count_r[nevs_pkg::IDX_W-1:0];

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (first) begin
        count_nxt = nevs_pkg::COUNT_W'(1);
      end else if (!full) begin
        count_nxt = count_r + nevs_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = accept && !first;
    chain[0].x         = in_chan.sample_value;
    chain[0].limit     = count_r;
    chain[0].full      = full;
  end

  for (genvar i = 0; i < nevs_pkg::DEPTH; i++) begin : g_cell
    nevs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (advance),
      .wr_en   (store_wr && (wr_idx == nevs_pkg::IDX_W'(i))),
      .wr_data (in_chan.sample_value),
      .idx     (nevs_pkg::IDX_W'(i)),
      .q_in    (chain[i]),
      .q_out   (chain[i+1])
    );
  end

  assign tail                 = chain[nevs_pkg::DEPTH];
  assign res.distance         = tail.best_dist;
  assign res.partner_position = nevs_pkg::POS_OUT_W'(tail.best_pos);
  assign res.store_full       = tail.full;

  nevs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (tail.valid),
    .res       (res),
    .advance   (advance),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

[sv/nevs_cell.sv]
// One cell of the search chain: holds one stored value and one query stage.
// Depends on nevs_pkg for query_t and sizes.
`default_nettype none

module nevs_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              wr_en,
  input  wire logic signed [nevs_pkg::VAL_W-1:0] wr_data,
  input  wire logic [nevs_pkg::IDX_W-1:0]        idx,
  input  wire nevs_pkg::query_t                  q_in,
  output nevs_pkg::query_t                       q_out
);

  logic signed [nevs_pkg::VAL_W-1:0] value_r;
  nevs_pkg::query_t                  q_r;
  nevs_pkg::query_t                  q_nxt;
  logic signed [nevs_pkg::VAL_W:0]   x_ext;
  logic signed [nevs_pkg::VAL_W:0]   v_ext;
  logic signed [nevs_pkg::VAL_W:0]   diff_xv;
  logic signed [nevs_pkg::VAL_W:0]   diff_vx;
  logic [nevs_pkg::VAL_W-1:0]        abs_diff;
  logic                              active;
  logic                              take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_r <= wr_data;
    end
  end

  always_comb begin
    x_ext    = {q_in.x[nevs_pkg::VAL_W-1], q_in.x};
    v_ext    = {value_r[nevs_pkg::VAL_W-1], value_r};
    diff_xv  = x_ext - v_ext;
    diff_vx  = v_ext - x_ext;
    abs_diff = diff_xv[nevs_pkg::VAL_W] ? diff_vx[nevs_pkg::VAL_W-1:0]
                                        : diff_xv[nevs_pkg::VAL_W-1:0];
    active   = q_in.valid && (nevs_pkg::COUNT_W'(idx) < q_in.limit);
    take     = active && ((q_in.best_pos == '0) || (abs_diff < q_in.best_dist) ||
               ((abs_diff == q_in.best_dist) && (value_r < q_in.best_val)));
    q_nxt    = q_in;
    if (take) begin
      q_nxt.best_dist = abs_diff;
      q_nxt.best_val  = value_r;
      q_nxt.best_pos  = nevs_pkg::POS_W'(idx) + nevs_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

`default_nettype wire

[sv/nevs_out_buf.sv]
// Output register with skid stage between the chain end and the result channel.
// Depends on nevs_pkg for result_t and on nevs_out_if.
`default_nettype none

module nevs_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire nevs_pkg::result_t res,
  output logic                   advance,
  nevs_out_if.source             out_chan
);

  logic              out_valid_r;
  logic              skid_valid_r;
  nevs_pkg::result_t out_data_r;
  nevs_pkg::result_t skid_data_r;
  logic              load;
  logic              out_free;

  assign advance  = !skid_valid_r;
  assign load     = res_valid && advance;
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= load;
      end
    end else if (load) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (load) begin
        out_data_r <= res;
      end
    end else if (load) begin
      skid_data_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.distance         = out_data_r.distance;
  assign out_chan.partner_position = out_data_r.partner_position;
  assign out_chan.store_full       = out_data_r.store_full;

endmodule

`default_nettype wire
